@@ sv/bpt_pkg.sv @@
// Shared types and constants for the barometric compensation block.
package bpt_pkg;

   // Field widths
   localparam int RAW_W   = 24;
   localparam int CAL_W   = 16;
   localparam int TEMP_W  = 19;
   localparam int PRESS_W = 32;
   localparam int WIDE_W  = 40;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes
   localparam logic [2:0] REG_SENS_BASE_C1        = 3'd0;
   localparam logic [2:0] REG_OFFSET_BASE_C2      = 3'd1;
   localparam logic [2:0] REG_SENS_TEMP_COEF_C3   = 3'd2;
   localparam logic [2:0] REG_OFFSET_TEMP_COEF_C4 = 3'd3;
   localparam logic [2:0] REG_REF_TEMP_C5         = 3'd4;
   localparam logic [2:0] REG_TEMP_SENS_C6        = 3'd5;

   // Temperature thresholds in 0.01 degC
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 19'sd2000;
   localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -19'sd1500;

   // Calibration words
   typedef struct packed {
      logic [CAL_W-1:0] sens_base_c1;
      logic [CAL_W-1:0] offset_base_c2;
      logic [CAL_W-1:0] sens_temp_coef_c3;
      logic [CAL_W-1:0] offset_temp_coef_c4;
      logic [CAL_W-1:0] ref_temp_c5;
      logic [CAL_W-1:0] temp_sens_c6;
   } cal_type;

   // First-order results
   typedef struct packed {
      logic [RAW_W-1:0]         raw_pressure;
      logic signed [TEMP_W-1:0] temp;
      logic signed [TEMP_W-1:0] temp_corr;
      logic signed [WIDE_W-1:0] offset;
      logic signed [WIDE_W-1:0] sens;
   } first_type;

   // Second-order corrected terms
   typedef struct packed {
      logic [RAW_W-1:0]         raw_pressure;
      logic signed [TEMP_W-1:0] temp;
      logic signed [WIDE_W-1:0] offset;
      logic signed [WIDE_W-1:0] sens;
   } second_type;

endpackage

@@ sv/bpt_if.sv @@
// Handshake channels for raw conversion pairs and compensated results.
interface bpt_req_if import bpt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_pressure;
   logic [RAW_W-1:0] raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpt_rsp_if import bpt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [PRESS_W-1:0] pressure_out;
   logic signed [TEMP_W-1:0]  temperature_out;

   modport source (output valid, output pressure_out, output temperature_out, input ready);
   modport sink   (input valid, input pressure_out, input temperature_out, output ready);
endinterface

@@ sv/baro_pressure_temp_compensation.sv @@
// Top level of the second-order barometric pressure and temperature compensation.
//
//   channel   direction   handshake       payload
//   req_if    in          valid/ready     raw_pressure, raw_temperature
//   rsp_if    out         valid/ready     pressure_out, temperature_out
//   csr_*     in/out      psel/penable    six 16-bit calibration words
//
// One transaction per clock is accepted while rsp_if is not stalled; the datapath
// has eight register stages (three first-order, two correction, three for the
// split 24x40 pressure product).
// Reset clears the stage valid bits and the calibration words.
// A stall on rsp_if holds only the stages that are full; empty stages keep
// loading, so bubbles close up and no transaction is lost or repeated.
module baro_pressure_temp_compensation import bpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bpt_req_if.sink               req_if,
   bpt_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cal_type    cal;
   logic       first_valid, first_ready;
   first_type  first_data;
   logic       second_valid, second_ready;
   second_type second_data;

   // Calibration registers
   bpt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cal     (cal)
   );

   // First-order terms
   bpt_first u_first (
      .clock           (clock),
      .reset           (reset),
      .cal             (cal),
      .in_valid        (req_if.valid),
      .in_ready        (req_if.ready),
      .raw_pressure    (req_if.raw_pressure),
      .raw_temperature (req_if.raw_temperature),
      .out_valid       (first_valid),
      .out_ready       (first_ready),
      .out_data        (first_data)
   );

   // Second-order corrections
   bpt_second u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (first_valid),
      .in_ready  (first_ready),
      .in_data   (first_data),
      .out_valid (second_valid),
      .out_ready (second_ready),
      .out_data  (second_data)
   );

   // Pressure product and output register
   bpt_press u_press (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (second_valid),
      .in_ready        (second_ready),
      .in_data         (second_data),
      .out_valid       (rsp_if.valid),
      .out_ready       (rsp_if.ready),
      .pressure_out    (rsp_if.pressure_out),
      .temperature_out (rsp_if.temperature_out)
   );

endmodule

@@ sv/bpt_csr.sv @@
// Calibration register file behind the APB-style port.
module bpt_csr import bpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cal_type               cal
);

   cal_type    cal_ff;
   cal_type    cal_in;
   logic       wr_en;
   logic [2:0] reg_idx;
   logic [CAL_W-1:0] wdata;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];
   assign wdata   = pwdata[CAL_W-1:0];
   assign pready  = 1'b1;
   assign cal     = cal_ff;

   // Decode the write; drop writes past the last register
   always_comb begin
      cal_in = cal_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SENS_BASE_C1:        cal_in.sens_base_c1        = wdata;
            REG_OFFSET_BASE_C2:      cal_in.offset_base_c2      = wdata;
            REG_SENS_TEMP_COEF_C3:   cal_in.sens_temp_coef_c3   = wdata;
            REG_OFFSET_TEMP_COEF_C4: cal_in.offset_temp_coef_c4 = wdata;
            REG_REF_TEMP_C5:         cal_in.ref_temp_c5         = wdata;
            REG_TEMP_SENS_C6:        cal_in.temp_sens_c6        = wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_SENS_BASE_C1:        prdata = {16'd0, cal_ff.sens_base_c1};
         REG_OFFSET_BASE_C2:      prdata = {16'd0, cal_ff.offset_base_c2};
         REG_SENS_TEMP_COEF_C3:   prdata = {16'd0, cal_ff.sens_temp_coef_c3};
         REG_OFFSET_TEMP_COEF_C4: prdata = {16'd0, cal_ff.offset_temp_coef_c4};
         REG_REF_TEMP_C5:         prdata = {16'd0, cal_ff.ref_temp_c5};
         REG_TEMP_SENS_C6:        prdata = {16'd0, cal_ff.temp_sens_c6};
         default:                 prdata = '0;
      endcase
   end

endmodule

@@ sv/bpt_first.sv @@
// First-order stages: temperature difference, products, TEMP, OFF and SENS.
module bpt_first import bpt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cal_type          cal,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [RAW_W-1:0] raw_pressure,
   input  logic [RAW_W-1:0] raw_temperature,
   output logic             out_valid,
   input  logic             out_ready,
   output first_type        out_data
);

   logic en_a, en_b, en_c;
   logic va_ff, vb_ff, vc_ff;
   logic va_in, vb_in, vc_in;

   logic signed [24:0] dt_ff, dt_in;
   logic [RAW_W-1:0]   d1a_ff, d1b_ff;

   logic signed [16:0] c3_s, c4_s, c6_s;
   logic signed [41:0] dtc6_ff, dtc6_in;
   logic signed [41:0] c4dt_ff, c4dt_in;
   logic signed [41:0] c3dt_ff, c3dt_in;
   logic signed [49:0] dtdt_ff, dtdt_in;

   logic signed [41:0] dtc6_sh;
   first_type          out_ff, out_in;

   // Stage enables: a stage loads when empty or when its successor moves
   assign en_c     = !vc_ff || out_ready;
   assign en_b     = !vb_ff || en_c;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   assign va_in = en_a ? in_valid : va_ff;
   assign vb_in = en_b ? va_ff : vb_ff;
   assign vc_in = en_c ? vb_ff : vc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   // Stage A: temperature difference against the reference
   assign dt_in = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ref_temp_c5, 8'd0});

   always_ff @(posedge clock) begin
      if (en_a) begin
         dt_ff  <= dt_in;
         d1a_ff <= raw_pressure;
      end
   end

   // Stage B: coefficient products and the square of the difference
   assign c3_s    = $signed({1'b0, cal.sens_temp_coef_c3});
   assign c4_s    = $signed({1'b0, cal.offset_temp_coef_c4});
   assign c6_s    = $signed({1'b0, cal.temp_sens_c6});
   assign dtc6_in = 42'(dt_ff) * 42'(c6_s);
   assign c4dt_in = 42'(dt_ff) * 42'(c4_s);
   assign c3dt_in = 42'(dt_ff) * 42'(c3_s);
   assign dtdt_in = 50'(dt_ff) * 50'(dt_ff);

   always_ff @(posedge clock) begin
      if (en_b) begin
         dtc6_ff <= dtc6_in;
         c4dt_ff <= c4dt_in;
         c3dt_ff <= c3dt_in;
         dtdt_ff <= dtdt_in;
         d1b_ff  <= d1a_ff;
      end
   end

   // Stage C: scale and add the bases
   assign dtc6_sh = dtc6_ff >>> 23;

   always_comb begin
      out_in.raw_pressure = d1b_ff;
      out_in.temp         = TEMP_HIGH + TEMP_W'(dtc6_sh);
      out_in.temp_corr    = TEMP_W'(dtdt_ff >>> 31);
      out_in.offset       = WIDE_W'($signed({1'b0, cal.offset_base_c2, 16'd0}))
                          + WIDE_W'(c4dt_ff >>> 7);
      out_in.sens         = WIDE_W'($signed({1'b0, cal.sens_base_c1, 15'd0}))
                          + WIDE_W'(c3dt_ff >>> 8);
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_data  = out_ff;

endmodule

@@ sv/bpt_second.sv @@
// Second-order stages: low and very low temperature corrections.
module bpt_second import bpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  first_type  in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output second_type out_data
);

   logic en_d, en_e;
   logic vd_ff, ve_ff;
   logic vd_in, ve_in;

   logic signed [19:0]       dm, dp;
   logic signed [WIDE_W-1:0] dd_ff, dd_in;
   logic signed [WIDE_W-1:0] ee_ff, ee_in;
   logic                     low_ff, low_in;
   logic                     vlow_ff, vlow_in;
   first_type                hold_ff;

   logic signed [WIDE_W-1:0] five_d, seven_e, eleven_e;
   logic signed [WIDE_W-1:0] off_sub_a, off_sub_b, sens_sub_a, sens_sub_b;
   logic signed [TEMP_W-1:0] temp_sub;
   second_type               out_ff, out_in;

   // Stage enables
   assign en_e     = !ve_ff || out_ready;
   assign en_d     = !vd_ff || en_e;
   assign in_ready = en_d;

   assign vd_in = en_d ? in_valid : vd_ff;
   assign ve_in = en_e ? vd_ff : ve_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         vd_ff <= vd_in;
         ve_ff <= ve_in;
      end
   end

   // Stage D: squared distances from both thresholds
   assign dm      = 20'(in_data.temp) - 20'(TEMP_HIGH);
   assign dp      = 20'(in_data.temp) - 20'(TEMP_LOW);
   assign dd_in   = WIDE_W'(dm) * WIDE_W'(dm);
   assign ee_in   = WIDE_W'(dp) * WIDE_W'(dp);
   assign low_in  = in_data.temp < TEMP_HIGH;
   assign vlow_in = in_data.temp < TEMP_LOW;

   always_ff @(posedge clock) begin
      if (en_d) begin
         dd_ff   <= dd_in;
         ee_ff   <= ee_in;
         low_ff  <= low_in;
         vlow_ff <= vlow_in;
         hold_ff <= in_data;
      end
   end

   // Stage E: subtract the corrections that apply
   assign five_d   = (dd_ff <<< 2) + dd_ff;
   assign seven_e  = (ee_ff <<< 3) - ee_ff;
   assign eleven_e = (ee_ff <<< 3) + (ee_ff <<< 1) + ee_ff;

   assign off_sub_a  = low_ff  ? (five_d >>> 1)   : '0;
   assign sens_sub_a = low_ff  ? (five_d >>> 2)   : '0;
   assign off_sub_b  = vlow_ff ? seven_e          : '0;
   assign sens_sub_b = vlow_ff ? (eleven_e >>> 1) : '0;
   assign temp_sub   = low_ff  ? hold_ff.temp_corr : '0;

   always_comb begin
      out_in.raw_pressure = hold_ff.raw_pressure;
      out_in.temp         = hold_ff.temp - temp_sub;
      out_in.offset       = hold_ff.offset - off_sub_a - off_sub_b;
      out_in.sens         = hold_ff.sens - sens_sub_a - sens_sub_b;
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = ve_ff;
   assign out_data  = out_ff;

endmodule

@@ sv/bpt_press.sv @@
// Pressure stages: split 24x40 product, recombine, offset and scale.
module bpt_press import bpt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  second_type                in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [PRESS_W-1:0] pressure_out,
   output logic signed [TEMP_W-1:0]  temperature_out
);

   logic en_f, en_g, en_h;
   logic vf_ff, vg_ff, vh_ff;
   logic vf_in, vg_in, vh_in;

   logic signed [19:0]       sens_hi;
   logic [43:0]              pl_ff, pl_in;
   logic signed [44:0]       ph_ff, ph_in;
   logic signed [WIDE_W-1:0] off_f_ff, off_g_ff;
   logic signed [TEMP_W-1:0] temp_f_ff, temp_g_ff;

   logic signed [63:0]       prod_ff, prod_in;
   logic signed [44:0]       diff;

   logic signed [PRESS_W-1:0] pressure_ff, pressure_in;
   logic signed [TEMP_W-1:0]  temperature_ff;

   // Stage enables
   assign en_h     = !vh_ff || out_ready;
   assign en_g     = !vg_ff || en_h;
   assign en_f     = !vf_ff || en_g;
   assign in_ready = en_f;

   assign vf_in = en_f ? in_valid : vf_ff;
   assign vg_in = en_g ? vf_ff : vg_ff;
   assign vh_in = en_h ? vg_ff : vh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
         vh_ff <= 1'b0;
      end else begin
         vf_ff <= vf_in;
         vg_ff <= vg_in;
         vh_ff <= vh_in;
      end
   end

   // Stage F: raw pressure times the low and high halves of SENS
   assign sens_hi = in_data.sens[39:20];
   assign pl_in   = 44'(in_data.raw_pressure) * 44'(in_data.sens[19:0]);
   assign ph_in   = 45'($signed({1'b0, in_data.raw_pressure})) * 45'(sens_hi);

   always_ff @(posedge clock) begin
      if (en_f) begin
         pl_ff     <= pl_in;
         ph_ff     <= ph_in;
         off_f_ff  <= in_data.offset;
         temp_f_ff <= in_data.temp;
      end
   end

   // Stage G: recombine the partial products
   assign prod_in = (64'(ph_ff) <<< 20) + $signed({20'd0, pl_ff});

   always_ff @(posedge clock) begin
      if (en_g) begin
         prod_ff   <= prod_in;
         off_g_ff  <= off_f_ff;
         temp_g_ff <= temp_f_ff;
      end
   end

   // Stage H: scale, remove the offset, keep the low word
   assign diff        = 45'(prod_ff >>> 21) - 45'(off_g_ff);
   assign pressure_in = PRESS_W'(diff >>> 15);

   always_ff @(posedge clock) begin
      if (en_h) begin
         pressure_ff    <= pressure_in;
         temperature_ff <= temp_g_ff;
      end
   end

   assign out_valid       = vh_ff;
   assign pressure_out    = pressure_ff;
   assign temperature_out = temperature_ff;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the second-order barometric compensation block.
module testbench;
   import bpt_pkg::*;

   localparam int         CAL_COUNT      = 6;
   localparam logic [2:0] UNMAPPED_LOW   = 3'd6;
   localparam logic [2:0] UNMAPPED_HIGH  = 3'd7;
   localparam longint     RAW_MAX        = 64'hFF_FFFF;
   localparam int         SETTLE_CYCLES  = 24;
   localparam int         TIMEOUT_CYCLES = 300000;

   // Typical factory calibration, used for the directed boundary items
   localparam logic [CSR_DATA_W-1:0] TYP_C1  = 32'd40127;
   localparam logic [CSR_DATA_W-1:0] TYP_C2  = 32'd36924;
   localparam logic [CSR_DATA_W-1:0] TYP_C3  = 32'd23317;
   localparam logic [CSR_DATA_W-1:0] TYP_C4  = 32'd23282;
   localparam logic [CSR_DATA_W-1:0] TYP_C5  = 32'd33464;
   localparam logic [CSR_DATA_W-1:0] TYP_C6  = 32'd28312;
   localparam logic [RAW_W-1:0]      TYP_REF = RAW_W'(TYP_C5 * 256);

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } conversion_type;

   typedef struct packed {
      logic signed [PRESS_W-1:0] pressure;
      logic signed [TEMP_W-1:0]  temperature;
   } reading_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bpt_req_if req_if();
   bpt_rsp_if rsp_if();

   conversion_type   conversion_queue[$];
   reading_type      expected_readings[$];
   logic [CAL_W-1:0] cal_words[CAL_COUNT];

   int pushed_count   = 0;
   int accepted_count = 0;
   int driven_count   = 0;
   int error_count    = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   bit idle_mode      = 1'b0;
   bit drain_pending  = 1'b0;
   bit req_taken      = 1'b0;

   baro_pressure_temp_compensation dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Bound the run in case the pipeline hangs
   initial begin : watchdog
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Compensate one conversion pair with the current calibration words
   function automatic reading_type compensate(input logic [RAW_W-1:0] raw_p,
                                              input logic [RAW_W-1:0] raw_t);
      longint      c1, c2, c3, c4, c5, c6;
      longint      dt, temp, offset, sens, sq, press;
      reading_type r;
      c1     = longint'(cal_words[REG_SENS_BASE_C1]);
      c2     = longint'(cal_words[REG_OFFSET_BASE_C2]);
      c3     = longint'(cal_words[REG_SENS_TEMP_COEF_C3]);
      c4     = longint'(cal_words[REG_OFFSET_TEMP_COEF_C4]);
      c5     = longint'(cal_words[REG_REF_TEMP_C5]);
      c6     = longint'(cal_words[REG_TEMP_SENS_C6]);
      dt     = longint'(raw_t) - c5 * 256;
      temp   = 2000 + ((dt * c6) >>> 23);
      offset = c2 * 65536 + ((c4 * dt) >>> 7);
      sens   = c1 * 32768 + ((c3 * dt) >>> 8);
      // Second-order correction below 20 degC, extra term below -15 degC
      if (temp < TEMP_HIGH) begin
         sq      = temp - TEMP_HIGH;
         sq      = 5 * sq * sq;
         offset -= sq >>> 1;
         sens   -= sq >>> 2;
         if (temp < TEMP_LOW) begin
            sq      = temp - TEMP_LOW;
            sq      = sq * sq;
            offset -= 7 * sq;
            sens   -= (11 * sq) >>> 1;
         end
         temp -= (dt * dt) >>> 31;
      end
      press         = (((longint'(raw_p) * sens) >>> 21) - offset) >>> 15;
      r.pressure    = press[PRESS_W-1:0];
      r.temperature = temp[TEMP_W-1:0];
      return r;
   endfunction

   task automatic queue_conversion(input logic [RAW_W-1:0] raw_p,
                                   input logic [RAW_W-1:0] raw_t);
      conversion_type c;
      c.raw_pressure    = raw_p;
      c.raw_temperature = raw_t;
      conversion_queue.push_back(c);
      pushed_count++;
   endtask

   // Random pairs, many of them landing around the reference temperature
   task automatic queue_random(input int count);
      logic [RAW_W-1:0] raw_p;
      longint           raw_t;
      int               span;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0:       raw_p = '0;
            1:       raw_p = '1;
            default: raw_p = RAW_W'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0:          raw_t = $urandom_range(0, 1) ? RAW_MAX : 0;
            1, 2, 3, 4: raw_t = longint'($urandom) & RAW_MAX;
            default: begin
               span  = $urandom_range(4, 23);
               raw_t = longint'(cal_words[REG_REF_TEMP_C5]) * 256 - (longint'(1) << span)
                       + longint'($urandom_range(0, 2 << span));
               if (raw_t < 0) raw_t = 0;
               else if (raw_t > RAW_MAX) raw_t = RAW_MAX;
            end
         endcase
         queue_conversion(raw_p, raw_t[RAW_W-1:0]);
      end
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // Out-of-range indexes are dropped by the block
      if (index < CAL_COUNT) cal_words[index] = value[CAL_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_calibration(input logic [CSR_DATA_W-1:0] w1, w2, w3, w4, w5, w6);
      csr_write(REG_SENS_BASE_C1, w1);
      csr_write(REG_OFFSET_BASE_C2, w2);
      csr_write(REG_SENS_TEMP_COEF_C3, w3);
      csr_write(REG_OFFSET_TEMP_COEF_C4, w4);
      csr_write(REG_REF_TEMP_C5, w5);
      csr_write(REG_TEMP_SENS_C6, w6);
   endtask

   // Read back every calibration word
   task automatic check_calibration();
      for (int i = 0; i < CAL_COUNT; i++) begin
         @(negedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         csr_paddr   <= CSR_ADDR_W'(i * 4);
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata !== CSR_DATA_W'(cal_words[i])) begin
            $error("calibration word %0d expected %0h got %0h", i, cal_words[i], csr_prdata);
            error_count++;
         end
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      while (accepted_count != pushed_count || expected_readings.size() != 0)
         @(negedge clock);
   endtask

   // Feed conversion pairs, with gap bursts and an occasional full drain
   always @(negedge clock) begin : feed_requests
      conversion_type pending;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (drain_pending) begin
            if (expected_readings.size() == 0) drain_pending = 1'b0;
            req_if.valid <= 1'b0;
         end else if (conversion_queue.size() > 0) begin
            pending = conversion_queue.pop_front();
            req_if.valid           <= 1'b1;
            req_if.raw_pressure    <= pending.raw_pressure;
            req_if.raw_temperature <= pending.raw_temperature;
            driven_count++;
            if (driven_count == 900 || $urandom_range(0, 249) == 0) drain_pending = 1'b1;
            if (idle_mode && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Stall the result channel in random bursts
   always @(negedge clock) begin : accept_results
      if (reset || !idle_mode) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Predict on each accepted pair, compare each accepted result
   always @(posedge clock) begin : check_readings
      reading_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_readings.size() == 0) begin
               $error("result with no pending conversion: pressure_out %0d temperature_out %0d",
                      rsp_if.pressure_out, rsp_if.temperature_out);
               error_count++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_if.pressure_out !== want.pressure) begin
                  $error("pressure_out expected %0d got %0d", want.pressure, rsp_if.pressure_out);
                  error_count++;
               end
               if (rsp_if.temperature_out !== want.temperature) begin
                  $error("temperature_out expected %0d got %0d",
                         want.temperature, rsp_if.temperature_out);
                  error_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            expected_readings.push_back(compensate(req_if.raw_pressure, req_if.raw_temperature));
            accepted_count++;
         end
      end
   end

   initial begin : sequencer
      reset                  = 1'b1;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      req_if.valid           = 1'b0;
      req_if.raw_pressure    = '0;
      req_if.raw_temperature = '0;
      rsp_if.ready           = 1'b0;
      foreach (cal_words[i]) cal_words[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset calibration: all words zero
      check_calibration();
      queue_conversion('0, '0);
      queue_conversion('1, '1);
      queue_conversion('0, '1);
      queue_conversion('1, '0);
      wait_drained();

      // Typical calibration; writes past the last register must not land
      load_calibration(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
      csr_write(UNMAPPED_LOW, 32'hDEAD_BEEF);
      csr_write(UNMAPPED_HIGH, 32'hFFFF_FFFF);
      check_calibration();
      queue_conversion('0, TYP_REF);                       // exactly 20 degC
      queue_conversion('1, TYP_REF - 24'd1);               // just below 20 degC
      queue_conversion(24'h555555, TYP_REF - 24'd1037020); // exactly -15 degC
      queue_conversion(24'hAAAAAA, TYP_REF - 24'd1037021); // just below -15 degC
      queue_conversion(24'd8077636, TYP_REF - 24'd500000);
      queue_conversion('1, TYP_REF + 24'd500000);
      queue_conversion('1, '0);
      queue_conversion('0, '1);
      queue_conversion('0, '0);
      queue_conversion('1, '1);
      idle_mode = 1'b1;
      queue_random(450);
      wait_drained();

      // Every word at its maximum, upper data bits set
      load_calibration('1, '1, '1, '1, '1, '1);
      check_calibration();
      queue_conversion('0, '0);
      queue_conversion('1, '1);
      queue_conversion('0, '1);
      queue_conversion('1, '0);
      queue_conversion('1, 24'hFFFF00);
      queue_random(300);
      wait_drained();

      // Random calibration without idling
      load_calibration($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      check_calibration();
      idle_mode = 1'b0;
      queue_random(350);
      wait_drained();

      load_calibration($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      check_calibration();
      idle_mode = 1'b1;
      queue_random(350);
      wait_drained();

      // Last stretch runs with gaps and stalls, then at full rate
      load_calibration($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      check_calibration();
      queue_random(150);
      wait_drained();
      idle_mode = 1'b0;
      queue_random(250);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/bpt_pkg.sv
sv/bpt_if.sv
sv/bpt_csr.sv
sv/bpt_first.sv
sv/bpt_second.sv
sv/bpt_press.sv
sv/baro_pressure_temp_compensation.sv
sim/testbench.sv
